>>> design/bsas_pkg.sv
// Shared types and constants for the best scope address selector.
package bsas_pkg;

  // Width of the fields in one beat
  localparam int unsigned ScopeW = 4;
  localparam int unsigned IndexW = 4;

  // Scope ranks, lowest to highest
  localparam logic [ScopeW-1:0] RANK_UNSPEC     = 4'd0;
  localparam logic [ScopeW-1:0] RANK_MC_NODE    = 4'd1;
  localparam logic [ScopeW-1:0] RANK_LOOPBACK   = 4'd2;
  localparam logic [ScopeW-1:0] RANK_MC_LINK    = 4'd3;
  localparam logic [ScopeW-1:0] RANK_LINK_LOCAL = 4'd4;
  localparam logic [ScopeW-1:0] RANK_MC_SITE    = 4'd5;
  localparam logic [ScopeW-1:0] RANK_SITE_LOCAL = 4'd6;
  localparam logic [ScopeW-1:0] RANK_MC_ORG     = 4'd7;
  localparam logic [ScopeW-1:0] RANK_MC_GLOBAL  = 4'd8;
  localparam logic [ScopeW-1:0] RANK_GLOBAL     = 4'd10;

  // IPv6 multicast scope nibbles
  localparam logic [3:0] MC_SCOPE_NODE   = 4'h1;
  localparam logic [3:0] MC_SCOPE_LINK   = 4'h2;
  localparam logic [3:0] MC_SCOPE_SITE   = 4'h5;
  localparam logic [3:0] MC_SCOPE_ORG    = 4'h8;
  localparam logic [3:0] MC_SCOPE_GLOBAL = 4'hE;

  // One input beat
  typedef struct packed {
    logic        is_ipv6;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
    logic        end_of_list;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic [ScopeW-1:0] item_scope;
    logic [IndexW-1:0] winner_index;
    logic [ScopeW-1:0] winner_scope;
    logic              list_done;
    logic              list_overflow;
  } out_item_t;

endpackage

>>> design/bsas_if.sv
// Valid/ready stream interfaces for the address and result channels.
interface bsas_in_if;
  logic               valid;
  logic               ready;
  bsas_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsas_out_if;
  logic                valid;
  logic                ready;
  bsas_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/bsas_classify.sv
// Scope rank classifier for one IPv4 or IPv6 address.
module bsas_classify (
  input  bsas_pkg::in_item_t             item_i,
  output logic [bsas_pkg::ScopeW-1:0]    rank_o
);
  import bsas_pkg::*;

  function automatic logic [ScopeW-1:0] rank_v4(input logic [31:0] a);
    logic [7:0] o1;
    logic [7:0] o2;
    o1 = a[31:24];
    o2 = a[23:16];
    if (a == 32'd0)                                  return RANK_UNSPEC;
    else if (o1 == 8'd127)                           return RANK_LOOPBACK;
    else if (o1 == 8'd10)                            return RANK_SITE_LOCAL;
    else if (o1 == 8'd172 && o2 inside {[8'd16:8'd31]}) return RANK_SITE_LOCAL;
    else if (o1 == 8'd192 && o2 == 8'd168)           return RANK_SITE_LOCAL;
    else if (o1[7:4] == 4'hE)                        return RANK_MC_GLOBAL;
    else                                             return RANK_GLOBAL;
  endfunction

  function automatic logic [ScopeW-1:0] rank_v6(input logic [63:0] hi,
                                                input logic [63:0] lo);
    logic [7:0] b0;
    logic [7:0] b1;
    logic       mc;
    logic [3:0] sc;
    logic       hi_zero;
    b0      = hi[63:56];
    b1      = hi[55:48];
    mc      = (b0 == 8'hFF);
    sc      = b1[3:0];
    hi_zero = (hi == 64'd0);
    if (hi_zero && lo[63:32] == 32'h0000_FFFF)  return rank_v4(lo[31:0]);
    else if (hi_zero && lo == 64'd0)            return RANK_UNSPEC;
    else if (mc && sc == MC_SCOPE_NODE)         return RANK_MC_NODE;
    else if (hi_zero && lo == 64'd1)            return RANK_LOOPBACK;
    else if (mc && sc == MC_SCOPE_LINK)         return RANK_MC_LINK;
    else if (b0 == 8'hFE && b1[7:6] == 2'b10)   return RANK_LINK_LOCAL;
    else if (mc && sc == MC_SCOPE_SITE)         return RANK_MC_SITE;
    else if (b0 == 8'hFE && b1[7:6] == 2'b11)   return RANK_SITE_LOCAL;
    else if (mc && sc == MC_SCOPE_ORG)          return RANK_MC_ORG;
    else if (mc && sc == MC_SCOPE_GLOBAL)       return RANK_MC_GLOBAL;
    else                                        return RANK_GLOBAL;
  endfunction

  // IPv4 ignores the upper word and the top half of the lower word
  assign rank_o = item_i.is_ipv6 ? rank_v6(item_i.addr_upper, item_i.addr_lower)
                                 : rank_v4(item_i.addr_lower[31:0]);

endmodule

>>> design/best_scope_address_selector_unit.sv
// Top level: scope classification and best-address tracking over a list.
//
// Usage: addresses arrive on in_chan_i, one per beat, with end_of_list set on
// the last address of a list. Each address gives exactly one result beat on
// out_chan_o: its own scope rank, the position and rank of the best address
// of the list so far (earliest wins on a tie) and whether the list is closed.
// Items at position MAX_ADDRS or later in a list are ranked but never win and
// carry list_overflow.
// Path: an accepted beat is registered in the input register, ranked and
// compared from there, then registered in the result register on out_chan_o.
// Throughput: one beat per cycle; the input register and the result register
// each advance whenever the stage after them is empty or being drained.
// Stall: when the receiver holds ready low, the result register holds, then
// the input register fills and ready on in_chan_i drops; nothing is lost.
// Reset: both registers empty, list position, winner position and winner rank
// cleared; the first beat after reset starts a new list.
module best_scope_address_selector_unit #(
  parameter int unsigned MAX_ADDRS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsas_in_if.sink     in_chan_i,
  bsas_out_if.source  out_chan_o
);
  import bsas_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_ADDRS + 1);
  localparam int unsigned IdxW = (PosW < IndexW) ? PosW : IndexW;
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_ADDRS);

  // Pipeline registers
  logic            in_valid_q;
  in_item_t        in_data_q;
  logic            out_valid_q;
  out_item_t       out_data_q;
  out_item_t       out_data_d;

  // List state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   best_pos_q, best_pos_d;
  logic [ScopeW-1:0] best_rank_q, best_rank_d;

  logic              out_free;
  logic              advance;
  logic              take_in;
  logic [ScopeW-1:0] rank;
  logic              over;

  // Handshake
  assign out_free  = !out_valid_q || out_chan_o.ready;
  assign advance   = in_valid_q && out_free;
  assign in_chan_i.ready = !in_valid_q || out_free;
  assign take_in   = in_chan_i.valid && in_chan_i.ready;

  assign out_chan_o.valid = out_valid_q;
  assign out_chan_o.data  = out_data_q;

  bsas_classify u_classify (
    .item_i (in_data_q),
    .rank_o (rank)
  );

  // Running maximum and position update
  always_comb begin
    over        = (pos_q >= PosMax);
    best_pos_d  = best_pos_q;
    best_rank_d = best_rank_q;
    pos_d       = pos_q;
    if (pos_q == '0) begin
      best_rank_d = rank;
      best_pos_d  = '0;
    end else if (!over && rank > best_rank_q) begin
      best_rank_d = rank;
      best_pos_d  = pos_q;
    end

    out_data_d.item_scope    = rank;
    out_data_d.winner_index  = IndexW'(best_pos_d[IdxW-1:0]);
    out_data_d.winner_scope  = best_rank_d;
    out_data_d.list_done     = in_data_q.end_of_list;
    out_data_d.list_overflow = over;

    if (in_data_q.end_of_list) begin
      pos_d       = '0;
      best_pos_d  = '0;
      best_rank_d = RANK_UNSPEC;
    end else if (!over) begin
      pos_d = pos_q + PosW'(1);
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      best_pos_q  <= '0;
      best_rank_q <= RANK_UNSPEC;
    end else begin
      if (in_chan_i.ready) begin
        in_valid_q <= in_chan_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        pos_q       <= pos_d;
        best_pos_q  <= best_pos_d;
        best_rank_q <= best_rank_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_data_q <= in_chan_i.data;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef SYNTHESIS
  // List position never passes its saturation point
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= PosMax)
    else $error("list position beyond saturation");

  // A pending closing result means the list state is already back to its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.list_done |-> pos_q == '0)
    else $error("list state not cleared after list end");

  // An in-range item can never outrank the winner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.list_overflow |->
      out_data_q.winner_scope >= out_data_q.item_scope)
    else $error("winner rank below item rank");

  // Ranks stay in their defined range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.winner_scope <= RANK_GLOBAL)
    else $error("winner rank out of range");
`endif

endmodule

>>> test/best_scope_address_selector_unit_checker.sv
// Result checker: predicts each result beat from the address beats and compares it.
module best_scope_address_selector_unit_checker
  import bsas_pkg::*;
#(
  parameter int unsigned MAX_ADDRS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        addr_valid_i,
  input  logic        addr_ready_i,
  input  in_item_t    addr_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  out_item_t   res_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Running state of the current list
  int unsigned       list_pos;
  logic [31:0]       lead_pos;
  logic [ScopeW-1:0] lead_rank;

  out_item_t   scope_results_q[$];
  int unsigned mismatches;

  // IPv4 scope ranking
  function automatic logic [ScopeW-1:0] scope_of_ipv4(input logic [31:0] a);
    logic [7:0] o1;
    logic [7:0] o2;
    o1 = a[31:24];
    o2 = a[23:16];
    if (a == 32'd0) return RANK_UNSPEC;
    if (o1 == 8'd127) return RANK_LOOPBACK;
    if (o1 == 8'd10) return RANK_SITE_LOCAL;
    if (o1 == 8'd172 && o2 >= 8'd16 && o2 <= 8'd31) return RANK_SITE_LOCAL;
    if (o1 == 8'd192 && o2 == 8'd168) return RANK_SITE_LOCAL;
    if (o1[7:4] == 4'he) return RANK_MC_GLOBAL;
    return RANK_GLOBAL;
  endfunction

  // IPv6 scope ranking; v4-mapped addresses fall back to the IPv4 rules
  function automatic logic [ScopeW-1:0] scope_of_ipv6(input logic [63:0] hi,
                                                       input logic [63:0] lo);
    logic [7:0] b0;
    logic [7:0] b1;
    logic       mc;
    logic [3:0] sc;
    b0 = hi[63:56];
    b1 = hi[55:48];
    mc = (b0 == 8'hff);
    sc = b1[3:0];
    if (hi == 64'd0 && lo[63:32] == 32'h0000ffff) return scope_of_ipv4(lo[31:0]);
    if (hi == 64'd0 && lo == 64'd0) return RANK_UNSPEC;
    if (mc && sc == MC_SCOPE_NODE) return RANK_MC_NODE;
    if (hi == 64'd0 && lo == 64'd1) return RANK_LOOPBACK;
    if (mc && sc == MC_SCOPE_LINK) return RANK_MC_LINK;
    if (b0 == 8'hfe && b1[7:6] == 2'b10) return RANK_LINK_LOCAL;
    if (mc && sc == MC_SCOPE_SITE) return RANK_MC_SITE;
    if (b0 == 8'hfe && b1[7:6] == 2'b11) return RANK_SITE_LOCAL;
    if (mc && sc == MC_SCOPE_ORG) return RANK_MC_ORG;
    if (mc && sc == MC_SCOPE_GLOBAL) return RANK_MC_GLOBAL;
    return RANK_GLOBAL;
  endfunction

  // Rank one address, update the list winner, queue the result beat
  function automatic void rank_and_track(input in_item_t it);
    out_item_t         r;
    logic [ScopeW-1:0] s;
    logic              over;
    s = it.is_ipv6 ? scope_of_ipv6(it.addr_upper, it.addr_lower)
                   : scope_of_ipv4(it.addr_lower[31:0]);
    over = (list_pos >= MAX_ADDRS);
    if (list_pos == 0) begin
      lead_rank = s;
      lead_pos  = '0;
    end else if (!over && s > lead_rank) begin
      lead_rank = s;
      lead_pos  = list_pos;
    end
    r.item_scope    = s;
    r.winner_index  = lead_pos[IndexW-1:0];
    r.winner_scope  = lead_rank;
    r.list_done     = it.end_of_list;
    r.list_overflow = over;
    scope_results_q.push_back(r);
    // list end clears the state; position saturates at MAX_ADDRS
    if (it.end_of_list) begin
      list_pos  = 0;
      lead_pos  = '0;
      lead_rank = RANK_UNSPEC;
    end else if (!over) begin
      list_pos++;
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on address beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      list_pos  = 0;
      lead_pos  = '0;
      lead_rank = RANK_UNSPEC;
      scope_results_q.delete();
      mismatches = 0;
    end else begin
      if (addr_valid_i && addr_ready_i) rank_and_track(addr_data_i);
      if (res_valid_i && res_ready_i) begin
        if (scope_results_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %p", $time, res_data_i);
          mismatches++;
        end else begin
          want = scope_results_q.pop_front();
          check_field("item_scope", 8'(want.item_scope), 8'(res_data_i.item_scope));
          check_field("winner_index", 8'(want.winner_index),
                      8'(res_data_i.winner_index));
          check_field("winner_scope", 8'(want.winner_scope),
                      8'(res_data_i.winner_scope));
          check_field("list_done", 8'(want.list_done), 8'(res_data_i.list_done));
          check_field("list_overflow", 8'(want.list_overflow),
                      8'(res_data_i.list_overflow));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= scope_results_q.size();
  end

endmodule

>>> test/best_scope_address_selector_unit_tb.sv
// Testbench top: address stimulus, result backpressure and the final verdict.
module best_scope_address_selector_unit_tb;
  import bsas_pkg::*;

  localparam int unsigned MaxAddrs  = 16;
  localparam int          HoldLen   = 80;
  localparam int          DrainWait = 20;

  logic clk_i = 1'b0;
  logic rst_ni;

  bsas_in_if  addr_chan ();
  bsas_out_if res_chan ();

  int unsigned fail_count;
  int unsigned pending;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_req;
  int stall_seen;
  int hold_left;

  always #1 clk_i = ~clk_i;

  best_scope_address_selector_unit #(
    .MAX_ADDRS(MaxAddrs)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_chan_i (addr_chan),
    .out_chan_o(res_chan)
  );

  best_scope_address_selector_unit_checker #(
    .MAX_ADDRS(MaxAddrs)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .addr_valid_i(addr_chan.valid),
    .addr_ready_i(addr_chan.ready),
    .addr_data_i (addr_chan.data),
    .res_valid_i (res_chan.valid),
    .res_ready_i (res_chan.ready),
    .res_data_i  (res_chan.data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Result side: random ready, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_chan.ready <= 1'b0;
      hold_left      <= 0;
      stall_seen     <= 0;
    end else if (stall_req != stall_seen) begin
      res_chan.ready <= 1'b0;
      hold_left      <= HoldLen;
      stall_seen     <= stall_req;
    end else if (hold_left != 0) begin
      res_chan.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else begin
      res_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic in_item_t ipv4_addr(input logic [31:0] a, input logic eol);
    in_item_t it;
    it.is_ipv6     = 1'b0;
    it.addr_upper  = '0;
    it.addr_lower  = {32'd0, a};
    it.end_of_list = eol;
    return it;
  endfunction

  function automatic in_item_t ipv6_addr(input logic [63:0] hi, input logic [63:0] lo,
                                         input logic eol);
    in_item_t it;
    it.is_ipv6     = 1'b1;
    it.addr_upper  = hi;
    it.addr_lower  = lo;
    it.end_of_list = eol;
    return it;
  endfunction

  // IPv4 value biased toward the ranges that matter, near misses included
  function automatic logic [31:0] random_ipv4();
    logic [31:0] a;
    a = $urandom;
    case ($urandom_range(0, 7))
      0: a = $urandom_range(0, 1) ? 32'd0 : {8'd127, a[23:0]};
      1: a[31:24] = 8'd10;
      2: a[31:16] = {8'd172, 4'd1, a[19:16]};
      3: a[31:16] = {8'd192, 8'd168};
      4: a[31:16] = $urandom_range(0, 1) ? {8'd172, 8'd15} : {8'd172, 8'd32};
      5: a[31:16] = $urandom_range(0, 1) ? {8'd192, 8'd167} : {8'd192, 8'd169};
      6: a[31:28] = 4'he;
      default: ;
    endcase
    return a;
  endfunction

  // One address beat from a mix of address classes, unused bits random
  function automatic in_item_t random_address(input logic eol);
    in_item_t it;
    it.is_ipv6     = 1'b1;
    it.addr_upper  = {$urandom, $urandom};
    it.addr_lower  = {$urandom, $urandom};
    it.end_of_list = eol;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        it.is_ipv6 = 1'b0;
        it.addr_lower[31:0] = random_ipv4();
      end
      3: begin
        it.addr_upper = '0;
        it.addr_lower = {32'h0000ffff, random_ipv4()};
      end
      4: begin
        it.addr_upper = '0;
        it.addr_lower = 64'($urandom_range(0, 1));
      end
      5: begin
        it.addr_upper[63:56] = 8'hff;
        case ($urandom_range(0, 5))
          0: it.addr_upper[51:48] = MC_SCOPE_NODE;
          1: it.addr_upper[51:48] = MC_SCOPE_LINK;
          2: it.addr_upper[51:48] = MC_SCOPE_SITE;
          3: it.addr_upper[51:48] = MC_SCOPE_ORG;
          4: it.addr_upper[51:48] = MC_SCOPE_GLOBAL;
          default: ;
        endcase
      end
      6: it.addr_upper[63:56] = 8'hfe;
      default: it.is_ipv6 = 1'($urandom_range(0, 1));
    endcase
    return it;
  endfunction

  // Offer one address beat, with random gaps, until it is taken
  task automatic send_addr(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      addr_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    addr_chan.valid <= 1'b1;
    addr_chan.data  <= it;
    @(posedge clk_i);
    while (!addr_chan.ready) @(posedge clk_i);
  endtask

  initial begin
    in_item_t directed[$];
    int       list_len;
    int       sent;

    rst_ni = 1'b0;
    addr_chan.valid <= 1'b0;
    addr_chan.data  <= '0;
    stall_req       <= 0;
    send_idle_pct    = 38;
    recv_idle_pct   <= 70;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // IPv4 ranks, private range edges, unused bits set
    directed.push_back(ipv4_addr(32'h00000000, 1'b0));
    directed.push_back(ipv4_addr(32'h7f000001, 1'b0));
    directed.push_back(ipv4_addr(32'h0a010203, 1'b0));
    directed.push_back(ipv4_addr(32'hac100001, 1'b0));
    directed.push_back(ipv4_addr(32'hac1fffff, 1'b1));
    directed.push_back(ipv4_addr(32'hac0f0001, 1'b0));
    directed.push_back(ipv4_addr(32'hc0a80101, 1'b0));
    directed.push_back(ipv4_addr(32'hc0a90000, 1'b1));
    directed.push_back(ipv4_addr(32'he0000001, 1'b0));
    directed.push_back(ipv4_addr(32'hf0000000, 1'b0));
    directed.push_back(ipv4_addr(32'hffffffff, 1'b0));
    directed.push_back(ipv6_addr('1, 64'hffffffff7f000001, 1'b1));
    directed[$].is_ipv6 = 1'b0;
    // IPv6 scopes in rising order
    directed.push_back(ipv6_addr(64'd0, 64'd0, 1'b0));
    directed.push_back(ipv6_addr(64'hff01000000000000, 64'd1, 1'b0));
    directed.push_back(ipv6_addr(64'd0, 64'd1, 1'b0));
    directed.push_back(ipv6_addr(64'hff02000000000000, 64'd1, 1'b0));
    directed.push_back(ipv6_addr(64'hfe80000000000000, 64'd1, 1'b0));
    directed.push_back(ipv6_addr(64'hff05000000000000, 64'd2, 1'b0));
    directed.push_back(ipv6_addr(64'hfec0000000000000, 64'd1, 1'b0));
    directed.push_back(ipv6_addr(64'hff08000000000000, 64'd1, 1'b0));
    directed.push_back(ipv6_addr(64'hff0e000000000000, 64'd1, 1'b0));
    directed.push_back(ipv6_addr(64'hff0f000000000000, 64'd1, 1'b1));
    // v4-mapped, non-matching fe00 prefix, all ones
    directed.push_back(ipv6_addr(64'd0, 64'h0000ffff0a000001, 1'b0));
    directed.push_back(ipv6_addr(64'd0, 64'h0000ffff00000000, 1'b0));
    directed.push_back(ipv6_addr(64'hfe00000000000000, 64'd0, 1'b0));
    directed.push_back(ipv6_addr('1, '1, 1'b1));
    foreach (directed[i]) send_addr(directed[i]);

    // Three idle patterns; the last one also holds the result side off
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 38;
          recv_idle_pct <= 70;
        end
        1: begin
          send_idle_pct  = 70;
          recv_idle_pct <= 38;
        end
        default: begin
          send_idle_pct  = 0;
          recv_idle_pct <= 0;
          stall_req     <= stall_req + 1;
        end
      endcase
      sent = 0;
      while (sent < 330) begin
        // mostly short lists, some around and past the overflow point
        if ($urandom_range(0, 7) == 0) list_len = $urandom_range(MaxAddrs - 2, MaxAddrs + 5);
        else list_len = $urandom_range(1, 8);
        for (int k = 0; k < list_len; k++) send_addr(random_address(k == list_len - 1));
        sent += list_len;
      end
    end
    addr_chan.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
